// File: rtl/sstab_pkg.sv
// Shared types, constants and helpers for the scoped symbol table stack.
package sstab_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int IDX_W           = $clog2(TABLE_ENTRIES);
    localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W          = 16;
    localparam int DEPTH_W         = 8;
    localparam int MAX_SCOPE_DEPTH = 255;
    localparam int KEY_W           = 64;
    localparam int SIZE_W          = 4;
    localparam int TYPE_W          = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [KEY_W-1:0] TMP_KEY = 64'h0000_0000_0070_6D74;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_ADDR     = 3'd1,
        OP_INSERT   = 3'd2,
        OP_PUSH_TMP = 3'd3,
        OP_POP_TMP  = 3'd4,
        OP_POP_TOP  = 3'd5,
        OP_ENTER    = 3'd6,
        OP_LEAVE    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_TMP   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_DEPTH     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_INT_SIZE    = 2'd0,
        CFG_STRING_SIZE = 2'd1,
        CFG_OTHER_SIZE  = 2'd2
    } cfg_idx_t;

    localparam logic [TYPE_W-1:0] TYPE_INT    = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_STRING = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_IDX_WAIT,
        S_POP_WAIT,
        S_LEAVE,
        S_LEAVE_CHK
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  type_code;
        logic               is_const;
        logic               is_init;
        logic [DEPTH_W-1:0] depth;
        logic [ADDR_W-1:0]  addr;
    } attr_t;

    localparam int ATTR_W = $bits(attr_t);

    function automatic logic [SIZE_W-1:0] size_of(
        input logic [TYPE_W-1:0] t,
        input logic [SIZE_W-1:0] int_sz,
        input logic [SIZE_W-1:0] str_sz,
        input logic [SIZE_W-1:0] oth_sz
    );
        logic [SIZE_W-1:0] s;
        if (t == TYPE_INT) begin
            s = int_sz;
        end else if (t == TYPE_STRING) begin
            s = str_sz;
        end else begin
            s = oth_sz;
        end
        return s;
    endfunction

endpackage

// File: rtl/sstab_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module sstab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/scoped_symbol_table_stack_core.sv
// Top level: scoped symbol table kept as a stack in two synchronous RAMs.
// Enter, push tmp and errors found at once finish from the execute state; addr by index and pops
// first wait for a RAM read; lookup and insert scan one entry per cycle from index 0 upward, up to count;
// leave pops top entries of the current depth until the top entry differs or the table is empty.
// One operation at a time, busy high until done; reset clears count, next address, depth
// and sizes (2/4/2), not the RAMs; done is a one-cycle strobe the receiver cannot stall.
module scoped_symbol_table_stack_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     opcode,
    input  logic [sstab_pkg::KEY_W-1:0]    name_key,
    input  logic [sstab_pkg::TYPE_W-1:0]   type_code,
    input  logic                           is_const,
    input  logic                           is_init,
    input  logic [sstab_pkg::IDX_W-1:0]    entry_index,
    input  logic                           cfg_write,
    input  logic [sstab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sstab_pkg::SIZE_W-1:0]   cfg_data,
    output logic                           done,
    output logic [2:0]                     status,
    output logic [sstab_pkg::IDX_W-1:0]    found_index,
    output logic [sstab_pkg::ADDR_W-1:0]   found_address,
    output logic [sstab_pkg::CNT_W-1:0]    removed_count
);

    import sstab_pkg::*;

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic                 cst_reg, init_reg;
    logic [IDX_W-1:0]     qidx_reg;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    naddr_reg, naddr_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    logic [SIZE_W-1:0]    int_size_reg, string_size_reg, other_size_reg;

    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     fidx_reg, fidx_next;
    logic [ADDR_W-1:0]    faddr_reg, faddr_next;
    logic [CNT_W-1:0]     rcount_reg, rcount_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [KEY_W-1:0]     name_wdata, name_rdata;
    attr_t                attr_wdata, attr_rdata;
    logic [ATTR_W-1:0]    attr_rbits;

    logic                 accept;
    logic [CNT_W-1:0]     count_dec;
    logic [IDX_W-1:0]     top_idx;
    logic                 is_empty, is_full, hit, scan_done, idx_ok, depth_match;
    logic                 do_append, do_pop;
    logic [KEY_W-1:0]     app_key;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign count_dec   = count_reg - CNT_W'(1);
    assign top_idx     = count_dec[IDX_W-1:0];
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign attr_rdata  = attr_t'(attr_rbits);
    assign hit         = cmp_valid_reg && (name_rdata == key_reg);
    assign scan_done   = !hit && (scan_reg == count_reg);
    assign idx_ok      = ({1'b0, qidx_reg} < count_reg);
    assign depth_match = (attr_rdata.depth == depth_reg);

    sstab_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_name_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (name_wdata),
        .raddr (ram_raddr),
        .rdata (name_rdata)
    );

    sstab_ram #(.WIDTH(ATTR_W), .DEPTH(TABLE_ENTRIES)) u_attr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (attr_wdata),
        .raddr (ram_raddr),
        .rdata (attr_rbits)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_LOOKUP, OP_INSERT: state_next = S_SCAN;
                    OP_ADDR:              state_next = idx_ok ? S_IDX_WAIT : S_IDLE;
                    OP_POP_TMP, OP_POP_TOP: state_next = is_empty ? S_IDLE : S_POP_WAIT;
                    OP_LEAVE:             state_next = (depth_reg == '0) ? S_IDLE : S_LEAVE;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (hit || scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDX_WAIT: state_next = S_IDLE;
            S_POP_WAIT: state_next = S_IDLE;
            S_LEAVE:    state_next = is_empty ? S_IDLE : S_LEAVE_CHK;
            S_LEAVE_CHK: state_next = depth_match ? S_LEAVE : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath, RAM control and results
    always_comb
    begin
        count_next     = count_reg;
        naddr_next     = naddr_reg;
        depth_next     = depth_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        removed_next   = removed_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        faddr_next     = faddr_reg;
        rcount_next    = rcount_reg;
        ram_raddr      = top_idx;
        do_append      = 1'b0;
        do_pop         = 1'b0;
        app_key        = key_reg;

        case (state_reg)
            S_EXEC:
            begin
                scan_next    = '0;
                removed_next = '0;
                fidx_next    = '0;
                faddr_next   = '0;
                rcount_next  = '0;
                status_next  = ST_OK;
                case (op_reg)
                    OP_ADDR:
                    begin
                        ram_raddr = qidx_reg;
                        if (!idx_ok)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_PUSH_TMP:
                    begin
                        done_next = 1'b1;
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end else begin
                            app_key   = TMP_KEY;
                            do_append = 1'b1;
                        end
                    end
                    OP_POP_TMP, OP_POP_TOP:
                    begin
                        if (is_empty)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                    end
                    OP_ENTER:
                    begin
                        done_next = 1'b1;
                        if (depth_reg == DEPTH_W'(MAX_SCOPE_DEPTH))
                        begin
                            status_next = ST_DEPTH;
                        end else begin
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                    OP_LEAVE:
                    begin
                        if (depth_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DEPTH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                ram_raddr    = scan_reg[IDX_W-1:0];
                cmp_idx_next = scan_reg[IDX_W-1:0];
                if (hit)
                begin
                    done_next = 1'b1;
                    if (op_reg == OP_LOOKUP)
                    begin
                        status_next = ST_OK;
                        fidx_next   = cmp_idx_reg;
                        faddr_next  = attr_rdata.addr;
                    end else begin
                        status_next = ST_EXISTS;
                    end
                end else if (scan_done)
                begin
                    done_next = 1'b1;
                    if (op_reg == OP_LOOKUP)
                    begin
                        status_next = ST_NOT_FOUND;
                    end else if (is_full)
                    begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_OK;
                        do_append   = 1'b1;
                    end
                end else begin
                    scan_next      = scan_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
            end
            S_IDX_WAIT:
            begin
                done_next  = 1'b1;
                fidx_next  = qidx_reg;
                faddr_next = attr_rdata.addr;
            end
            S_POP_WAIT:
            begin
                done_next = 1'b1;
                if ((op_reg == OP_POP_TMP) && (name_rdata != TMP_KEY))
                begin
                    status_next = ST_NOT_TMP;
                end else begin
                    do_pop     = 1'b1;
                    fidx_next  = top_idx;
                    faddr_next = attr_rdata.addr;
                end
            end
            S_LEAVE:
            begin
                if (is_empty)
                begin
                    done_next   = 1'b1;
                    rcount_next = removed_reg;
                    depth_next  = depth_reg - DEPTH_W'(1);
                end
            end
            S_LEAVE_CHK:
            begin
                if (depth_match)
                begin
                    do_pop       = 1'b1;
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    done_next   = 1'b1;
                    rcount_next = removed_reg;
                    depth_next  = depth_reg - DEPTH_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        ram_we               = do_append;
        ram_waddr            = count_reg[IDX_W-1:0];
        name_wdata           = app_key;
        attr_wdata.type_code = type_reg;
        attr_wdata.is_const  = (op_reg == OP_INSERT) ? cst_reg : 1'b0;
        attr_wdata.is_init   = (op_reg == OP_INSERT) ? init_reg : 1'b0;
        attr_wdata.depth     = depth_reg;
        attr_wdata.addr      = naddr_reg;

        if (do_append)
        begin
            count_next = count_reg + CNT_W'(1);
            naddr_next = naddr_reg + ADDR_W'(size_of(type_reg, int_size_reg,
                                                     string_size_reg, other_size_reg));
            fidx_next  = count_reg[IDX_W-1:0];
            faddr_next = naddr_reg;
        end
        if (do_pop)
        begin
            count_next = count_dec;
            naddr_next = naddr_reg - ADDR_W'(size_of(attr_rdata.type_code, int_size_reg,
                                                     string_size_reg, other_size_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            naddr_reg     <= '0;
            depth_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            naddr_reg     <= naddr_next;
            depth_reg     <= depth_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_size_reg    <= SIZE_W'(2);
            string_size_reg <= SIZE_W'(4);
            other_size_reg  <= SIZE_W'(2);
        end else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INT_SIZE:    int_size_reg    <= cfg_data;
                CFG_STRING_SIZE: string_size_reg <= cfg_data;
                CFG_OTHER_SIZE:  other_size_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(opcode);
            key_reg  <= name_key;
            type_reg <= type_code;
            cst_reg  <= is_const;
            init_reg <= is_init;
            qidx_reg <= entry_index;
        end
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        fidx_reg    <= fidx_next;
        faddr_reg   <= faddr_next;
        rcount_reg  <= rcount_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found_index   = fidx_reg;
    assign found_address = faddr_reg;
    assign removed_count = rcount_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while an operation is still running");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("transfer accepted but block not busy");

    a_write_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!is_full && ((op_reg == OP_INSERT) || (op_reg == OP_PUSH_TMP))))
        else $error("table write outside an append");

endmodule
